FILE: hdl/rvid_pkg.sv
// Shared types, opcode constants and the format lookup for the RV32 instruction decoder.
package rvid_pkg;

  localparam int unsigned InstrWidth  = 32;
  localparam int unsigned RegIdxWidth = 5;
  localparam int unsigned FormatWidth = 3;
  localparam int unsigned KeyWidth    = 15;
  localparam int unsigned MajorWidth  = 5;

  // Instruction format codes as they appear on the format_kind output.
  typedef enum logic [FormatWidth-1:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } rvid_format_e;

  // Major opcodes (instruction bits 6:2) that the decoder recognizes.
  localparam logic [MajorWidth-1:0] OPC_LOAD     = 5'b00000;
  localparam logic [MajorWidth-1:0] OPC_MISC_MEM = 5'b00011;
  localparam logic [MajorWidth-1:0] OPC_OP_IMM   = 5'b00100;
  localparam logic [MajorWidth-1:0] OPC_AUIPC    = 5'b00101;
  localparam logic [MajorWidth-1:0] OPC_STORE    = 5'b01000;
  localparam logic [MajorWidth-1:0] OPC_AMO      = 5'b01011;
  localparam logic [MajorWidth-1:0] OPC_OP       = 5'b01100;
  localparam logic [MajorWidth-1:0] OPC_LUI      = 5'b01101;
  localparam logic [MajorWidth-1:0] OPC_BRANCH   = 5'b11000;
  localparam logic [MajorWidth-1:0] OPC_JALR     = 5'b11001;
  localparam logic [MajorWidth-1:0] OPC_JAL      = 5'b11011;
  localparam logic [MajorWidth-1:0] OPC_SYSTEM   = 5'b11100;

  // The two low opcode bits of every 32-bit instruction.
  localparam logic [1:0] OPC_QUADRANT_32 = 2'b11;

  typedef struct packed {
    logic         mapped;
    rvid_format_e fmt;
  } rvid_fmt_t;

  typedef struct packed {
    logic                          is_legal;
    logic [FormatWidth-1:0]        format_kind;
    logic [RegIdxWidth-1:0]        dest_reg;
    logic [RegIdxWidth-1:0]        src1_reg;
    logic [RegIdxWidth-1:0]        src2_reg;
    logic signed [InstrWidth-1:0]  immediate;
    logic [KeyWidth-1:0]           dispatch_key;
  } rvid_result_t;

  // Maps a major opcode to its format; unmapped opcodes come back with mapped low.
  function automatic rvid_fmt_t rvid_fmt_lookup(input logic [MajorWidth-1:0] major);
    rvid_fmt_t res;
    res.mapped = 1'b1;
    res.fmt    = FMT_R;
    case (major)
      OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_JALR, OPC_SYSTEM: res.fmt = FMT_I;
      OPC_AUIPC, OPC_LUI:                                      res.fmt = FMT_U;
      OPC_STORE:                                               res.fmt = FMT_S;
      OPC_AMO, OPC_OP:                                         res.fmt = FMT_R;
      OPC_BRANCH:                                              res.fmt = FMT_B;
      OPC_JAL:                                                 res.fmt = FMT_J;
      default:                                                 res.mapped = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/rvid_if.sv
// Valid/ready channel interfaces for instruction words and decode results.
interface rvid_instr_if;
  logic                               valid;
  logic                               ready;
  logic [rvid_pkg::InstrWidth-1:0]    instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvid_result_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  is_legal;
  logic [rvid_pkg::FormatWidth-1:0]      format_kind;
  logic [rvid_pkg::RegIdxWidth-1:0]      dest_reg;
  logic [rvid_pkg::RegIdxWidth-1:0]      src1_reg;
  logic [rvid_pkg::RegIdxWidth-1:0]      src2_reg;
  logic signed [rvid_pkg::InstrWidth-1:0] immediate;
  logic [rvid_pkg::KeyWidth-1:0]         dispatch_key;

  modport source (output valid, output is_legal, output format_kind, output dest_reg,
                  output src1_reg, output src2_reg, output immediate, output dispatch_key,
                  input ready);
  modport sink   (input valid, input is_legal, input format_kind, input dest_reg,
                  input src1_reg, input src2_reg, input immediate, input dispatch_key,
                  output ready);
endinterface

FILE: hdl/rvid_decode.sv
// Combinational field extraction, immediate assembly and dispatch key for one word.
module rvid_decode (
  input  logic [rvid_pkg::InstrWidth-1:0] instr_i,
  output rvid_pkg::rvid_result_t          result_o
);

  logic [rvid_pkg::MajorWidth-1:0] major;
  logic [2:0]                      funct3;
  logic [6:0]                      funct7;
  logic [6:0]                      funct7_key;
  rvid_pkg::rvid_fmt_t             fmt_info;
  logic                            legal;

  assign major    = instr_i[6:2];
  assign funct3   = instr_i[14:12];
  assign funct7   = instr_i[31:25];
  assign fmt_info = rvid_pkg::rvid_fmt_lookup(major);
  assign legal    = fmt_info.mapped && (instr_i[1:0] == rvid_pkg::OPC_QUADRANT_32);

  // AMO keeps aq/rl out of the key so all orderings dispatch alike.
  assign funct7_key = (major == rvid_pkg::OPC_AMO) ? {funct7[6:2], 2'b00} : funct7;

  always_comb begin
    result_o = '0;
    if (legal) begin
      result_o.is_legal    = 1'b1;
      result_o.format_kind = fmt_info.fmt;
      result_o.dest_reg    = instr_i[11:7];
      result_o.src1_reg    = instr_i[19:15];
      result_o.src2_reg    = instr_i[24:20];
      case (fmt_info.fmt)
        rvid_pkg::FMT_R: begin
          result_o.dispatch_key = {funct7_key, funct3, major};
        end
        rvid_pkg::FMT_I: begin
          result_o.src2_reg     = '0;
          result_o.immediate    = {{20{instr_i[31]}}, instr_i[31:20]};
          result_o.dispatch_key = {7'b0, funct3, major};
        end
        rvid_pkg::FMT_S: begin
          result_o.dest_reg     = '0;
          result_o.immediate    = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
          result_o.dispatch_key = {7'b0, funct3, major};
        end
        rvid_pkg::FMT_B: begin
          result_o.dest_reg     = '0;
          result_o.immediate    = {{19{instr_i[31]}}, instr_i[31], instr_i[7],
                                   instr_i[30:25], instr_i[11:8], 1'b0};
          result_o.dispatch_key = {7'b0, funct3, major};
        end
        rvid_pkg::FMT_U: begin
          result_o.src1_reg     = '0;
          result_o.src2_reg     = '0;
          result_o.immediate    = {instr_i[31:12], 12'b0};
          result_o.dispatch_key = {10'b0, major};
        end
        rvid_pkg::FMT_J: begin
          result_o.src1_reg     = '0;
          result_o.src2_reg     = '0;
          result_o.immediate    = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12],
                                   instr_i[20], instr_i[30:21], 1'b0};
          result_o.dispatch_key = {10'b0, major};
        end
        default: begin
          result_o = '0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/rv_instruction_decoder_unit.sv
// Top level of the RV32 instruction decoder: input register, decode logic, result register.
// A word waits in the input register until the result register can take its decode.
// Throughput: one instruction word per cycle unless result_o stalls; the decode path between
// the two registers is a single pass of shallow field-select and mux logic.
// Each register loads when it is empty or its content moves on, so a stalled result holds
// the input stage, and the input stalls only when both stages are full.
// Reset clears only the two stage valid flags; the data registers need no reset.
module rv_instruction_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  rvid_instr_if.sink   instr_i,
  rvid_result_if.source result_o
);

  // Input stage: captures the raw word whenever it is empty or will empty this cycle.
  logic                            in_valid_q;
  logic                            in_valid_d;
  logic [rvid_pkg::InstrWidth-1:0] word_q;

  // Result stage: holds one decoded result until the consumer takes it.
  logic                   out_valid_q;
  logic                   out_valid_d;
  rvid_pkg::rvid_result_t res_q;
  rvid_pkg::rvid_result_t res_d;

  logic out_ready;
  logic in_ready;
  logic in_xfer;
  logic advance;

  // The result register can load when it is empty or its content is being transferred.
  assign out_ready = !out_valid_q || result_o.ready;
  // The input register can load when it is empty or its word moves to the result stage.
  assign in_ready  = !in_valid_q || out_ready;
  assign advance   = in_valid_q && out_ready;
  assign in_xfer   = instr_i.valid && in_ready;

  assign instr_i.ready = in_ready;

  // The decode itself is pure logic on the registered word.
  rvid_decode u_decode (
    .instr_i  (word_q),
    .result_o (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready) begin
      in_valid_d = instr_i.valid;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= instr_i.instr_word;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.is_legal     = res_q.is_legal;
  assign result_o.format_kind  = res_q.format_kind;
  assign result_o.dest_reg     = res_q.dest_reg;
  assign result_o.src1_reg     = res_q.src1_reg;
  assign result_o.src2_reg     = res_q.src2_reg;
  assign result_o.immediate    = res_q.immediate;
  assign result_o.dispatch_key = res_q.dispatch_key;

  // A word held in the input stage during an output stall must not be lost or changed.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_ready) |=> (in_valid_q && $stable(word_q)))
    else $error("input stage lost or changed its word during a stall");

  // A word moving to the result stage must show up there in the next cycle.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced word did not reach the result stage");

  // A rejected word reports zero in every other field.
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.is_legal) |->
      (res_q.format_kind == '0 && res_q.dest_reg == '0 && res_q.src1_reg == '0 &&
       res_q.src2_reg == '0 && res_q.immediate == '0 && res_q.dispatch_key == '0))
    else $error("illegal word reported nonzero fields");

  // U and J formats carry only the major opcode in the key and no source registers.
  a_uj_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.is_legal &&
     (res_q.format_kind == rvid_pkg::FMT_U || res_q.format_kind == rvid_pkg::FMT_J)) |->
      (res_q.dispatch_key[rvid_pkg::KeyWidth-1:rvid_pkg::MajorWidth] == '0 &&
       res_q.src1_reg == '0 && res_q.src2_reg == '0))
    else $error("U/J result carries funct bits or source registers");

  // The R format has no immediate.
  a_r_no_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.is_legal && res_q.format_kind == rvid_pkg::FMT_R) |->
      (res_q.immediate == '0))
    else $error("R-format result carries an immediate");

endmodule

FILE: tb/sv/rvid_decode_checker.sv
// Checker for the RV32 instruction decoder: predicts each decode and compares the results.
module rvid_decode_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  rvid_instr_if  instr_mon,
  rvid_result_if result_mon,
  output int     error_count_o,
  output int     pending_decodes_o
);
  import rvid_pkg::*;

  localparam logic [6:0] AMO_ORDER_MASK = 7'b1111100;

  rvid_result_t decoded_q[$];
  int           mismatch_count;

  // Decodes one instruction word the way the block is meant to.
  function automatic rvid_result_t decode_word(input logic [InstrWidth-1:0] w);
    rvid_result_t          res;
    logic [MajorWidth-1:0] major;
    logic [2:0]            funct3;
    logic [6:0]            funct7;
    major  = w[6:2];
    funct3 = w[14:12];
    funct7 = w[31:25];
    res    = '0;
    if (w[1:0] != OPC_QUADRANT_32) begin
      return res;
    end
    res.is_legal = 1'b1;
    case (major)
      OPC_AMO, OPC_OP: begin
        if (major == OPC_AMO) begin
          funct7 = funct7 & AMO_ORDER_MASK;
        end
        res.format_kind  = FMT_R;
        res.dest_reg     = w[11:7];
        res.src1_reg     = w[19:15];
        res.src2_reg     = w[24:20];
        res.dispatch_key = {funct7, funct3, major};
      end
      OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_JALR, OPC_SYSTEM: begin
        res.format_kind  = FMT_I;
        res.dest_reg     = w[11:7];
        res.src1_reg     = w[19:15];
        res.immediate    = {{20{w[31]}}, w[31:20]};
        res.dispatch_key = {7'd0, funct3, major};
      end
      OPC_STORE: begin
        res.format_kind  = FMT_S;
        res.src1_reg     = w[19:15];
        res.src2_reg     = w[24:20];
        res.immediate    = {{20{w[31]}}, w[31:25], w[11:7]};
        res.dispatch_key = {7'd0, funct3, major};
      end
      OPC_BRANCH: begin
        res.format_kind  = FMT_B;
        res.src1_reg     = w[19:15];
        res.src2_reg     = w[24:20];
        res.immediate    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        res.dispatch_key = {7'd0, funct3, major};
      end
      OPC_AUIPC, OPC_LUI: begin
        res.format_kind  = FMT_U;
        res.dest_reg     = w[11:7];
        res.immediate    = {w[31:12], 12'd0};
        res.dispatch_key = {10'd0, major};
      end
      OPC_JAL: begin
        res.format_kind  = FMT_J;
        res.dest_reg     = w[11:7];
        res.immediate    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        res.dispatch_key = {10'd0, major};
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  initial begin
    error_count_o     = 0;
    pending_decodes_o = 0;
    mismatch_count    = 0;
  end

  always @(posedge clk_i) begin : watch
    rvid_result_t got;
    rvid_result_t want;
    if (rst_ni) begin
      if (result_mon.valid && result_mon.ready) begin
        got.is_legal     = result_mon.is_legal;
        got.format_kind  = result_mon.format_kind;
        got.dest_reg     = result_mon.dest_reg;
        got.src1_reg     = result_mon.src1_reg;
        got.src2_reg     = result_mon.src2_reg;
        got.immediate    = result_mon.immediate;
        got.dispatch_key = result_mon.dispatch_key;
        if (decoded_q.size() == 0) begin
          error_count_o++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("decode result with nothing outstanding: legal=%0b fmt=%0d key=%h",
                     got.is_legal, got.format_kind, got.dispatch_key);
          end
        end else begin
          want = decoded_q.pop_front();
          if (got.is_legal !== want.is_legal || got.format_kind !== want.format_kind ||
              got.dest_reg !== want.dest_reg || got.src1_reg !== want.src1_reg ||
              got.src2_reg !== want.src2_reg || got.immediate !== want.immediate ||
              got.dispatch_key !== want.dispatch_key) begin
            error_count_o++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp legal=%0b fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h key=%h",
                       want.is_legal, want.format_kind, want.dest_reg, want.src1_reg,
                       want.src2_reg, want.immediate, want.dispatch_key);
              $display("          got legal=%0b fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h key=%h",
                       got.is_legal, got.format_kind, got.dest_reg, got.src1_reg,
                       got.src2_reg, got.immediate, got.dispatch_key);
            end
          end
        end
      end
      if (instr_mon.valid && instr_mon.ready) begin
        decoded_q.push_back(decode_word(instr_mon.instr_word));
      end
    end
    pending_decodes_o = decoded_q.size();
  end

endmodule

FILE: tb/sv/rv_instruction_decoder_unit_test.sv
// Testbench top for the RV32 instruction decoder: clock, reset, stimulus and verdict.
module rv_instruction_decoder_unit_test;
  import rvid_pkg::*;

  // Every major opcode that decodes to a format; random legal words draw from this list.
  localparam logic [MajorWidth-1:0] MAPPED_MAJORS [12] = '{
    OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_AUIPC, OPC_STORE, OPC_AMO,
    OPC_OP, OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM
  };
  localparam int WORDS_PER_PHASE = 283;
  localparam int HOLD_OFF_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_cycles;
  int   error_count;
  int   pending_decodes;

  rvid_instr_if  instr_ch ();
  rvid_result_if result_ch ();

  rv_instruction_decoder_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .instr_i  (instr_ch),
    .result_o (result_ch)
  );

  rvid_decode_checker checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .instr_mon         (instr_ch),
    .result_mon        (result_ch),
    .error_count_o     (error_count),
    .pending_decodes_o (pending_decodes)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // A generous upper bound; a correct run finishes far sooner even with all stalls.
  initial begin
    #3000000;
    $display("[rv_instruction_decoder_unit] ERROR");
    $finish;
  end

  // Draws a random instruction word. Most words carry a mapped major opcode with
  // random upper bits, so every format sees plenty of random register and immediate
  // content. The rest are either fully random words (mostly the wrong quadrant) or
  // words in the 32-bit quadrant whose major opcode maps to no format.
  function automatic logic [InstrWidth-1:0] random_word();
    int                    pick;
    logic [MajorWidth-1:0] major;
    logic                  hit;
    logic [InstrWidth-1:0] w;
    pick = $urandom_range(99);
    w    = $urandom();
    if (pick < 75) begin
      major = MAPPED_MAJORS[$urandom_range(11)];
      return {w[31:7], major, OPC_QUADRANT_32};
    end else if (pick < 90) begin
      return w;
    end
    do begin
      major = MajorWidth'($urandom_range(31));
      hit   = 1'b0;
      foreach (MAPPED_MAJORS[k]) begin
        if (MAPPED_MAJORS[k] == major) begin
          hit = 1'b1;
        end
      end
    end while (hit);
    return {w[31:7], major, OPC_QUADRANT_32};
  endfunction

  // Offers one word and returns at the falling edge after its transfer. The task is
  // entered at a falling edge and touches valid at most once per falling edge, so a
  // valid that stays high between back-to-back words is never lowered and raised in
  // the same step.
  task automatic send_word(input logic [InstrWidth-1:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.instr_word <= w;
    do begin
      @(posedge clk);
    end while (!instr_ch.ready);
    @(negedge clk);
  endtask

  // Result side. A long hold-off is counted down here, by one at each falling edge;
  // otherwise ready drops at random according to the current idle rate.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    logic [InstrWidth-1:0] directed_q[$];
    rst_n               = 1'b0;
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    tx_idle_pct         = 22;
    rx_idle_pct         = 46;
    hold_cycles         = 0;

    // Directed words: both quadrant extremes and the two other non-32-bit quadrants,
    // an unmapped major opcode in the 32-bit quadrant, every mapped major opcode with
    // all upper bits set (most negative immediates, registers 31, full keys), a few
    // formats with all upper bits clear, and an atomic with only aq and rl set so the
    // key must come out with funct7 fully cleared.
    directed_q.push_back(32'h0000_0000);
    directed_q.push_back(32'hFFFF_FFFF);
    directed_q.push_back(32'hFFFF_FFFD);
    directed_q.push_back(32'hFFFF_FFFE);
    directed_q.push_back({25'd0, 5'b00001, OPC_QUADRANT_32});
    foreach (MAPPED_MAJORS[k]) begin
      directed_q.push_back({25'h1FF_FFFF, MAPPED_MAJORS[k], OPC_QUADRANT_32});
    end
    directed_q.push_back({25'd0, OPC_JAL, OPC_QUADRANT_32});
    directed_q.push_back({25'd0, OPC_BRANCH, OPC_QUADRANT_32});
    directed_q.push_back({25'd0, OPC_STORE, OPC_QUADRANT_32});
    directed_q.push_back({5'd0, 2'b11, 18'd0, OPC_AMO, OPC_QUADRANT_32});
    directed_q.push_back({1'b0, 24'hFF_FFFF, OPC_JAL, OPC_QUADRANT_32});

    // Reset is held and then released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[k]) begin
      send_word(directed_q[k]);
    end

    // Three random phases: the sender idles less than the receiver, then the other
    // way round, then both run flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 46;
        end
        1: begin
          tx_idle_pct = 46;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Back-pressure: the receiver stops for a long stretch while words keep
        // coming, which fills both pipeline stages and must stall the input.
        if (phase == 0 && i == 100) begin
          hold_cycles = HOLD_OFF_CYCLES;
        end
        // Drain: the sender goes quiet until every outstanding decode has come out,
        // so the next word enters an empty pipeline.
        if (phase == 1 && i == 150) begin
          instr_ch.valid <= 1'b0;
          wait (pending_decodes == 0);
          @(negedge clk);
        end
        send_word(random_word());
      end
    end

    // Let the pipeline empty, then keep watching for any stray result before the verdict.
    instr_ch.valid <= 1'b0;
    wait (pending_decodes == 0);
    repeat (10) @(negedge clk);

    if (error_count == 0 && pending_decodes == 0) begin
      $display("[rv_instruction_decoder_unit] OK");
    end else begin
      $display("[rv_instruction_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
